// ----- rtl/url_query_splitter_decoder_top_assert.svh -----
// assertion macros for the url query splitter
`ifndef URL_QUERY_SPLITTER_DECODER_TOP_ASSERT_SVH
`define URL_QUERY_SPLITTER_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UQSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UQSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/uqsd_pkg.sv -----
package uqsd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] part_t;

  // special characters
  localparam byte_t CH_QUESTION = 8'h3F;
  localparam byte_t CH_AMP      = 8'h26;
  localparam byte_t CH_EQUALS   = 8'h3D;
  localparam byte_t CH_PERCENT  = 8'h25;

  // part tags on the result channel
  localparam part_t PART_PATH  = 2'd0;
  localparam part_t PART_NAME  = 2'd1;
  localparam part_t PART_VALUE = 2'd2;

  // bytes of a percent triple held in a value
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_PCT  = 2'd1;
  localparam logic [1:0] PEND_BYTE = 2'd2;

  // result slots per item
  localparam int MAX_RES = 5;

  typedef enum logic [2:0] {
    MODE_PATH  = 3'b001,
    MODE_NAME  = 3'b010,
    MODE_VALUE = 3'b100
  } mode_t;

  typedef struct packed {
    logic  has_byte;
    byte_t out_byte;
    part_t part;
    logic  part_end;
    logic  string_end;
  } res_t;

  // character result
  function automatic res_t mk_byte(byte_t b, part_t p);
    res_t r;
    r.has_byte   = 1'b1;
    r.out_byte   = b;
    r.part       = p;
    r.part_end   = 1'b0;
    r.string_end = 1'b0;
    return r;
  endfunction

  // end marker result
  function automatic res_t mk_mark(part_t p, logic send);
    res_t r;
    r.has_byte   = 1'b0;
    r.out_byte   = 8'h00;
    r.part       = p;
    r.part_end   = 1'b1;
    r.string_end = send;
    return r;
  endfunction

  // hex digit decode: {ok, nibble}
  function automatic logic [4:0] hex_dec(byte_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- rtl/uqsd_ifs.sv -----
// input channel: one url character per item
interface uqsd_in_if;
  import uqsd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  is_final;
  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

// result channel: tagged characters and end markers
interface uqsd_out_if;
  import uqsd_pkg::*;
  logic  valid;
  logic  ready;
  logic  has_byte;
  byte_t out_byte;
  part_t part;
  logic  part_end;
  logic  string_end;
  logic  run_last;
  modport source (output valid, output has_byte, output out_byte, output part,
                  output part_end, output string_end, output run_last, input ready);
  modport sink (input valid, input has_byte, input out_byte, input part,
                input part_end, input string_end, input run_last, output ready);
endinterface

// ----- rtl/url_query_splitter_decoder_top.sv -----
// channel | dir | payload
// in_ch   | in  | in_byte[7:0], is_final
// out_ch  | out | has_byte, out_byte[7:0], part[1:0], part_end, string_end, run_last
//
// an item is decoded as it is taken and its 0 to 5 results land in a result buffer
// an item with at most one result flows at one item per cycle while out_ch.ready is high
// an item with n results holds the buffer until all n are taken; the next item is taken with the last
// items that give no result (held percent bytes) show nothing
// rst_n (synchronous) clears parse mode, held percent bytes and the result buffer
// out_ch.ready low holds the current result, and in_ch while any result waits

`include "url_query_splitter_decoder_top_assert.svh"

module url_query_splitter_decoder_top (
  input  logic clk,
  input  logic rst_n,
  uqsd_in_if.sink    in_ch,
  uqsd_out_if.source out_ch
);
  import uqsd_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  pc_r, pc_nxt;
  byte_t       pf_r, pf_nxt;

  res_t        entries_r [MAX_RES];
  res_t        list [MAX_RES];
  logic [2:0]  cnt_r;
  logic [2:0]  idx_r;
  logic [2:0]  n;

  logic [4:0]  hi, lo;
  logic        in_take, out_take, last_take;
  res_t        cur;

  // buffer handshake
  assign cur       = entries_r[idx_r];
  assign out_take  = out_ch.valid && out_ch.ready;
  assign last_take = out_take && ((idx_r + 3'd1) == cnt_r);
  assign in_ch.ready = (cnt_r == 3'd0) || last_take;
  assign in_take   = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = (cnt_r != 3'd0);
  assign out_ch.has_byte   = cur.has_byte;
  assign out_ch.out_byte   = cur.out_byte;
  assign out_ch.part       = cur.part;
  assign out_ch.part_end   = cur.part_end;
  assign out_ch.string_end = cur.string_end;
  assign out_ch.run_last   = ((idx_r + 3'd1) == cnt_r);

  // decode one item into its result list
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      list[i] = '0;
    end
    n        = 3'd0;
    mode_nxt = mode_r;
    pc_nxt   = pc_r;
    pf_nxt   = pf_r;
    hi       = hex_dec(pf_r);
    lo       = hex_dec(in_ch.in_byte);

    case (mode_r)
      MODE_NAME: begin
        if (in_ch.in_byte == CH_EQUALS) begin
          list[n] = mk_mark(PART_NAME, 1'b0); n = n + 3'd1;
          mode_nxt = MODE_VALUE;
          pc_nxt   = PEND_NONE;
        end else if (in_ch.in_byte == CH_AMP) begin
          list[n] = mk_mark(PART_NAME, 1'b0);  n = n + 3'd1;
          list[n] = mk_mark(PART_VALUE, 1'b0); n = n + 3'd1;
        end else begin
          list[n] = mk_byte(in_ch.in_byte, PART_NAME); n = n + 3'd1;
        end
      end
      MODE_VALUE: begin
        if (in_ch.in_byte == CH_AMP) begin
          if (pc_r != PEND_NONE) begin
            list[n] = mk_byte(CH_PERCENT, PART_VALUE); n = n + 3'd1;
          end
          if (pc_r == PEND_BYTE) begin
            list[n] = mk_byte(pf_r, PART_VALUE); n = n + 3'd1;
          end
          list[n] = mk_mark(PART_VALUE, 1'b0); n = n + 3'd1;
          pc_nxt   = PEND_NONE;
          pf_nxt   = 8'h00;
          mode_nxt = MODE_NAME;
        end else if (pc_r == PEND_NONE) begin
          if (in_ch.in_byte == CH_PERCENT) begin
            pc_nxt = PEND_PCT;
          end else begin
            list[n] = mk_byte(in_ch.in_byte, PART_VALUE); n = n + 3'd1;
          end
        end else if (pc_r == PEND_PCT) begin
          pf_nxt = in_ch.in_byte;
          pc_nxt = PEND_BYTE;
        end else begin
          // third byte of a triple: decode or pass all three
          if (hi[4] && lo[4]) begin
            list[n] = mk_byte({hi[3:0], lo[3:0]}, PART_VALUE); n = n + 3'd1;
          end else begin
            list[n] = mk_byte(CH_PERCENT, PART_VALUE);     n = n + 3'd1;
            list[n] = mk_byte(pf_r, PART_VALUE);           n = n + 3'd1;
            list[n] = mk_byte(in_ch.in_byte, PART_VALUE);  n = n + 3'd1;
          end
          pc_nxt = PEND_NONE;
          pf_nxt = 8'h00;
        end
      end
      default: begin
        if (in_ch.in_byte == CH_QUESTION) begin
          list[n] = mk_mark(PART_PATH, 1'b0); n = n + 3'd1;
          mode_nxt = MODE_NAME;
        end else begin
          list[n] = mk_byte(in_ch.in_byte, PART_PATH); n = n + 3'd1;
        end
      end
    endcase

    // close the open parts at the end of the url
    if (in_ch.is_final) begin
      case (mode_nxt)
        MODE_NAME: begin
          list[n] = mk_mark(PART_NAME, 1'b0);  n = n + 3'd1;
          list[n] = mk_mark(PART_VALUE, 1'b1); n = n + 3'd1;
        end
        MODE_VALUE: begin
          if (pc_nxt != PEND_NONE) begin
            list[n] = mk_byte(CH_PERCENT, PART_VALUE); n = n + 3'd1;
          end
          if (pc_nxt == PEND_BYTE) begin
            list[n] = mk_byte(pf_nxt, PART_VALUE); n = n + 3'd1;
          end
          list[n] = mk_mark(PART_VALUE, 1'b1); n = n + 3'd1;
        end
        default: begin
          list[n] = mk_mark(PART_PATH, 1'b1); n = n + 3'd1;
        end
      endcase
      mode_nxt = MODE_PATH;
      pc_nxt   = PEND_NONE;
      pf_nxt   = 8'h00;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PATH;
      pc_r   <= PEND_NONE;
      pf_r   <= 8'h00;
    end else if (in_take) begin
      mode_r <= mode_nxt;
      pc_r   <= pc_nxt;
      pf_r   <= pf_nxt;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 3'd0;
    end else if (in_take) begin
      cnt_r <= n;
      idx_r <= 3'd0;
    end else if (last_take) begin
      cnt_r <= 3'd0;
      idx_r <= 3'd0;
    end else if (out_take) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < MAX_RES; i++) begin
        entries_r[i] <= list[i];
      end
    end
  end

  `UQSD_ASSERT_NOW(a_take_only_on_drain, in_take && out_ch.valid, out_ch.ready && out_ch.run_last, "item taken while results still wait")
  `UQSD_ASSERT_NOW(a_idx_in_range, cnt_r != 3'd0, idx_r < cnt_r && cnt_r <= 3'd5, "result index out of range")
  `UQSD_ASSERT_NEXT(a_final_resets, in_take && in_ch.is_final, mode_r == MODE_PATH && pc_r == PEND_NONE, "state not cleared after url end")
  `UQSD_ASSERT_NOW(a_pending_in_value, pc_r != PEND_NONE, mode_r == MODE_VALUE && pc_r <= PEND_BYTE, "held percent outside a value")

endmodule
